### design/hcbd_pkg.sv
package hcbd_pkg;

	// bus commands
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_IRQ   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// owner of an access
	typedef enum logic [2:0] {
		TGT_INTERNAL = 3'd0,
		TGT_CART_ROM = 3'd1,
		TGT_CART_RAM = 3'd2,
		TGT_VIDEO    = 3'd3,
		TGT_TIMER    = 3'd4
	} target_t;

	// internal store that serves an access
	typedef enum logic [2:0] {
		RG_NONE   = 3'd0,
		RG_WRAM   = 3'd1,
		RG_UNUSE  = 3'd2,
		RG_IO     = 3'd3,
		RG_IFLAG  = 3'd4,
		RG_HRAM   = 3'd5,
		RG_IE     = 3'd6
	} region_t;

	localparam int unsigned WRAM_DEPTH = 8192;
	localparam int unsigned WRAM_AW    = $clog2(WRAM_DEPTH);
	// I/O bytes in the lower half, high RAM in the upper half
	localparam int unsigned HI_DEPTH   = 256;
	localparam int unsigned HI_AW      = $clog2(HI_DEPTH);
	localparam int unsigned IO_DEPTH   = 128;
	localparam int unsigned IO_AW      = $clog2(IO_DEPTH);
	localparam int unsigned IRQ_COUNT  = 5;

	localparam logic [15:0] ADDR_VIDEO   = 16'h8000;
	localparam logic [15:0] ADDR_CRAM    = 16'hA000;
	localparam logic [15:0] ADDR_WRAM    = 16'hC000;
	localparam logic [15:0] ADDR_OAM     = 16'hFE00;
	localparam logic [15:0] ADDR_UNUSE   = 16'hFEA0;
	localparam logic [15:0] ADDR_IO      = 16'hFF00;
	localparam logic [15:0] ADDR_SB      = 16'hFF01;
	localparam logic [15:0] ADDR_SC      = 16'hFF02;
	localparam logic [15:0] ADDR_TIM_LO  = 16'hFF04;
	localparam logic [15:0] ADDR_TIM_HI  = 16'hFF07;
	localparam logic [15:0] ADDR_IF      = 16'hFF0F;
	localparam logic [15:0] ADDR_LCD_LO  = 16'hFF40;
	localparam logic [15:0] ADDR_LCD_HI  = 16'hFF4B;
	localparam logic [15:0] ADDR_DMA     = 16'hFF46;
	localparam logic [15:0] ADDR_VBK     = 16'hFF4F;
	localparam logic [15:0] ADDR_PAL_LO  = 16'hFF68;
	localparam logic [15:0] ADDR_PAL_HI  = 16'hFF6C;
	localparam logic [15:0] ADDR_HRAM    = 16'hFF80;
	localparam logic [15:0] ADDR_IE      = 16'hFFFF;

	localparam logic [7:0] IF_READ_SET  = 8'hE0;
	localparam logic [7:0] SC_KEEP_MASK = 8'h7F;
	localparam logic [7:0] UNUSE_READ   = 8'hFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [2:0]  interrupt_index;
	} req_item_t;

	typedef struct packed {
		logic [2:0] target;
		logic [7:0] read_data;
		logic       serial_valid;
		logic [7:0] serial_byte;
	} rsp_item_t;

	typedef struct packed {
		target_t target;
		region_t region;
	} dec_t;

endpackage

### design/hcbd_ram.sv
module hcbd_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/hcbd_decode.sv
module hcbd_decode (
	input  logic [15:0]      address,
	output hcbd_pkg::dec_t   dec
);

	// owner of an I/O address
	function automatic hcbd_pkg::target_t io_target(input logic [15:0] a);
		hcbd_pkg::target_t t;
		t = hcbd_pkg::TGT_INTERNAL;
		if (a >= hcbd_pkg::ADDR_TIM_LO && a <= hcbd_pkg::ADDR_TIM_HI) begin
			t = hcbd_pkg::TGT_TIMER;
		end else if (a >= hcbd_pkg::ADDR_LCD_LO && a <= hcbd_pkg::ADDR_LCD_HI
				&& a != hcbd_pkg::ADDR_DMA) begin
			t = hcbd_pkg::TGT_VIDEO;
		end else if (a == hcbd_pkg::ADDR_VBK) begin
			t = hcbd_pkg::TGT_VIDEO;
		end else if (a >= hcbd_pkg::ADDR_PAL_LO && a <= hcbd_pkg::ADDR_PAL_HI) begin
			t = hcbd_pkg::TGT_VIDEO;
		end
		return t;
	endfunction

	// memory map
	always_comb begin
		dec.target = hcbd_pkg::TGT_INTERNAL;
		dec.region = hcbd_pkg::RG_NONE;
		if (address < hcbd_pkg::ADDR_VIDEO) begin
			dec.target = hcbd_pkg::TGT_CART_ROM;
		end else if (address < hcbd_pkg::ADDR_CRAM) begin
			dec.target = hcbd_pkg::TGT_VIDEO;
		end else if (address < hcbd_pkg::ADDR_WRAM) begin
			dec.target = hcbd_pkg::TGT_CART_RAM;
		end else if (address < hcbd_pkg::ADDR_OAM) begin
			dec.region = hcbd_pkg::RG_WRAM;
		end else if (address < hcbd_pkg::ADDR_UNUSE) begin
			dec.target = hcbd_pkg::TGT_VIDEO;
		end else if (address < hcbd_pkg::ADDR_IO) begin
			dec.region = hcbd_pkg::RG_UNUSE;
		end else if (address < hcbd_pkg::ADDR_HRAM) begin
			dec.target = io_target(address);
			if (dec.target == hcbd_pkg::TGT_INTERNAL) begin
				dec.region = (address == hcbd_pkg::ADDR_IF) ? hcbd_pkg::RG_IFLAG
					: hcbd_pkg::RG_IO;
			end
		end else if (address < hcbd_pkg::ADDR_IE) begin
			dec.region = hcbd_pkg::RG_HRAM;
		end else begin
			dec.region = hcbd_pkg::RG_IE;
		end
	end

endmodule

### design/handheld_console_bus_decoder.sv
// Bus decoder for a handheld console memory map.
// Request channel (req_valid, req_stall, req): one bus access per item,
// a byte read, a byte write or an interrupt request.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one item per
// request, in order: owning target, read byte, and the serial byte when a
// write to the serial control register starts a transfer.
// The request passes a read stage register and then the response register.
// The request is held off while the previous one waits in the read stage for
// the registered read data of the work RAM or the I/O / high RAM memory.
// Reset clears the interrupt flag and enable registers, the serial data
// shadow and the valid bits of the I/O bytes (unwritten I/O bytes read 0);
// work RAM and high RAM have no reset and no clearing pass.
// While the receiver stalls, the response register holds its item and
// requests are held off; an item already in the read stage waits there
// until the response register drains.
module handheld_console_bus_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  hcbd_pkg::req_item_t   req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output hcbd_pkg::rsp_item_t   rsp
);

	hcbd_pkg::dec_t             dec;
	hcbd_pkg::target_t          tgt;
	logic                       accept;
	logic                       is_wr;
	logic                       sc_start;
	logic                       wram_we;
	logic                       hi_we;
	logic [7:0]                 hi_wdata;
	logic [7:0]                 wram_rdata;
	logic [7:0]                 hi_rdata;
	logic                       s1_adv;
	logic [7:0]                 rd_s1;

	logic [4:0]                 ifl_q;
	logic [7:0]                 ie_q;
	logic [7:0]                 sb_q;
	logic [hcbd_pkg::IO_DEPTH-1:0] io_vld_q;

	logic                       s1_valid_q;
	logic                       rd_s1_en;
	logic                       rd_en_s1;
	hcbd_pkg::region_t          region_s1;
	hcbd_pkg::target_t          target_s1;
	logic                       iovld_s1;
	logic                       ser_v_s1;
	logic [7:0]                 ser_b_s1;

	logic                       rsp_valid_q;
	hcbd_pkg::rsp_item_t        rsp_q;

	hcbd_decode u_decode (
		.address (req.address),
		.dec     (dec)
	);

	// accept and write control
	assign req_stall = s1_valid_q || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign is_wr     = accept && req.command == hcbd_pkg::CMD_WRITE
		&& dec.target == hcbd_pkg::TGT_INTERNAL;
	assign sc_start  = is_wr && req.address == hcbd_pkg::ADDR_SC && req.write_data[7];
	assign wram_we   = is_wr && dec.region == hcbd_pkg::RG_WRAM;
	assign hi_we     = is_wr && (dec.region == hcbd_pkg::RG_IO
		|| dec.region == hcbd_pkg::RG_HRAM);
	assign hi_wdata  = sc_start ? (req.write_data & hcbd_pkg::SC_KEEP_MASK) : req.write_data;
	assign tgt       = (req.command == hcbd_pkg::CMD_READ
		|| req.command == hcbd_pkg::CMD_WRITE) ? dec.target : hcbd_pkg::TGT_INTERNAL;
	assign rd_s1_en  = accept && req.command == hcbd_pkg::CMD_READ;

	hcbd_ram #(
		.DEPTH (hcbd_pkg::WRAM_DEPTH),
		.WIDTH (8)
	) u_wram (
		.clk   (clk),
		.we    (wram_we),
		.waddr (req.address[hcbd_pkg::WRAM_AW-1:0]),
		.wdata (req.write_data),
		.re    (rd_s1_en),
		.raddr (req.address[hcbd_pkg::WRAM_AW-1:0]),
		.rdata (wram_rdata)
	);

	hcbd_ram #(
		.DEPTH (hcbd_pkg::HI_DEPTH),
		.WIDTH (8)
	) u_hiram (
		.clk   (clk),
		.we    (hi_we),
		.waddr (req.address[hcbd_pkg::HI_AW-1:0]),
		.wdata (hi_wdata),
		.re    (rd_s1_en),
		.raddr (req.address[hcbd_pkg::HI_AW-1:0]),
		.rdata (hi_rdata)
	);

	// register file: interrupt flags, enable, serial data shadow, io valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ifl_q    <= '0;
			ie_q     <= '0;
			sb_q     <= '0;
			io_vld_q <= '0;
		end else begin
			if (accept && req.command == hcbd_pkg::CMD_IRQ
					&& req.interrupt_index < 3'(hcbd_pkg::IRQ_COUNT)) begin
				ifl_q <= ifl_q | (5'd1 << req.interrupt_index);
			end
			if (is_wr && dec.region == hcbd_pkg::RG_IFLAG) begin
				ifl_q <= req.write_data[4:0];
			end
			if (is_wr && dec.region == hcbd_pkg::RG_IE) begin
				ie_q <= req.write_data;
			end
			if (is_wr && req.address == hcbd_pkg::ADDR_SB) begin
				sb_q <= req.write_data;
			end
			if (hi_we && dec.region == hcbd_pkg::RG_IO) begin
				io_vld_q[req.address[hcbd_pkg::IO_AW-1:0]] <= 1'b1;
			end
		end
	end

	// read stage control
	assign s1_adv = s1_valid_q && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_en_s1  <= rd_s1_en;
			region_s1 <= dec.region;
			target_s1 <= tgt;
			iovld_s1  <= io_vld_q[req.address[hcbd_pkg::IO_AW-1:0]];
			ser_v_s1  <= sc_start;
			ser_b_s1  <= sc_start ? sb_q : 8'd0;
		end
	end

	// read data select
	always_comb begin
		rd_s1 = 8'd0;
		if (rd_en_s1 && target_s1 == hcbd_pkg::TGT_INTERNAL) begin
			case (region_s1)
				hcbd_pkg::RG_WRAM:  rd_s1 = wram_rdata;
				hcbd_pkg::RG_UNUSE: rd_s1 = hcbd_pkg::UNUSE_READ;
				hcbd_pkg::RG_IFLAG: rd_s1 = hcbd_pkg::IF_READ_SET | {3'd0, ifl_q};
				hcbd_pkg::RG_IO:    rd_s1 = iovld_s1 ? hi_rdata : 8'd0;
				hcbd_pkg::RG_HRAM:  rd_s1 = hi_rdata;
				hcbd_pkg::RG_IE:    rd_s1 = ie_q;
				default:            rd_s1 = 8'd0;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.target       <= target_s1;
			rsp_q.read_data    <= rd_s1;
			rsp_q.serial_valid <= ser_v_s1;
			rsp_q.serial_byte  <= ser_b_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### design/hcbd_checker.sv
module hcbd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input hcbd_pkg::rsp_item_t rsp
);

	// forwarded accesses carry no read byte
	a_fwd_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.target != hcbd_pkg::TGT_INTERNAL |-> rsp.read_data == 8'd0)
		else $error("forwarded item with read data");

	// serial byte only with a transfer start
	a_ser_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.serial_valid |-> rsp.serial_byte == 8'd0)
		else $error("serial byte without transfer start");

	// transfer start comes from an internal write
	a_ser_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.serial_valid |->
			rsp.target == hcbd_pkg::TGT_INTERNAL && rsp.read_data == 8'd0)
		else $error("serial start on a non-write item");

	// one item at a time: request held off after each accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item accepted back to back");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind handheld_console_bus_decoder hcbd_checker u_hcbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/tb_handheld_console_bus_decoder.sv
module tb_handheld_console_bus_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import hcbd_pkg::*;

	localparam int          RANDOM_ITEMS = 1025;
	localparam int          CALM_ITEMS   = 150;
	localparam int          LIMIT_CYCLES = 200000;
	localparam int          MAX_PRINTS   = 40;
	localparam logic [15:0] ECHO_BASE    = 16'hE000;
	localparam int          ECHO_SPAN    = 'h1E00;
	localparam int          HRAM_SPAN    = 127;

	typedef struct {
		req_item_t req;
		bit        given;
		rsp_item_t rsp;
	} step_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// predicted state of the internal stores
	logic [7:0] wram_copy [8192];
	logic [7:0] hram_copy [128];
	logic [7:0] io_copy   [128] = '{default: 8'h00};
	logic [4:0] iflag_copy = '0;
	logic [7:0] ie_copy    = '0;

	// entries the stimulus has written, so reads only hit written RAM
	bit wram_seen [8192];
	int wram_used [$];
	bit hram_seen [128];
	int hram_used [$];

	step_t     plan [$];
	step_t     typed_rsp [$];
	rsp_item_t pending_rsp [$];

	bit calm    = 1'b0;
	bit tx_busy = 1'b1;
	int errors  = 0;
	int cycles  = 0;
	int n_rsp   = 0;
	int n_read  = 0;
	int n_write = 0;
	int n_irq   = 0;
	int n_other = 0;
	int n_serial = 0;

	handheld_console_bus_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// owner of a bus address
	function automatic target_t owner_of(input logic [15:0] a);
		if (a < ADDR_VIDEO) return TGT_CART_ROM;
		if (a < ADDR_CRAM) return TGT_VIDEO;
		if (a < ADDR_WRAM) return TGT_CART_RAM;
		if (a < ADDR_OAM) return TGT_INTERNAL;
		if (a < ADDR_UNUSE) return TGT_VIDEO;
		if (a < ADDR_IO || a >= ADDR_HRAM) return TGT_INTERNAL;
		if (a >= ADDR_TIM_LO && a <= ADDR_TIM_HI) return TGT_TIMER;
		if (a >= ADDR_LCD_LO && a <= ADDR_LCD_HI && a != ADDR_DMA) return TGT_VIDEO;
		if (a == ADDR_VBK || (a >= ADDR_PAL_LO && a <= ADDR_PAL_HI)) return TGT_VIDEO;
		return TGT_INTERNAL;
	endfunction

	// byte served internally; work RAM and its echo share the low 13 address bits
	function automatic logic [7:0] fetch_byte(input logic [15:0] a);
		if (a < ADDR_OAM) return wram_copy[a[12:0]];
		if (a < ADDR_IO) return UNUSE_READ;
		if (a == ADDR_IF) return IF_READ_SET | {3'b000, iflag_copy};
		if (a < ADDR_HRAM) return io_copy[a[6:0]];
		if (a < ADDR_IE) return hram_copy[a[6:0]];
		return ie_copy;
	endfunction

	// internal store, with the serial transfer start on the control register
	function automatic void store_byte(input logic [15:0] a, input logic [7:0] v,
			output logic sent, output logic [7:0] sbyte);
		sent  = 1'b0;
		sbyte = '0;
		if (a < ADDR_OAM) begin
			wram_copy[a[12:0]] = v;
		end else if (a < ADDR_IO) begin
			// unusable region ignores writes
		end else if (a == ADDR_IF) begin
			iflag_copy = v[4:0];
		end else if (a < ADDR_HRAM) begin
			io_copy[a[6:0]] = v;
			if (a == ADDR_SC && v[7]) begin
				sent  = 1'b1;
				sbyte = io_copy[ADDR_SB[6:0]];
				io_copy[ADDR_SC[6:0]] = v & SC_KEEP_MASK;
			end
		end else if (a < ADDR_IE) begin
			hram_copy[a[6:0]] = v;
		end else begin
			ie_copy = v;
		end
	endfunction

	// expected response of one bus access, updating the predicted state
	function automatic rsp_item_t bus_access(input req_item_t it);
		rsp_item_t r;
		target_t   owner;
		r     = '0;
		owner = owner_of(it.address);
		case (cmd_t'(it.command))
			CMD_READ: begin
				r.target = owner;
				if (owner == TGT_INTERNAL) r.read_data = fetch_byte(it.address);
			end
			CMD_WRITE: begin
				r.target = owner;
				if (owner == TGT_INTERNAL)
					store_byte(it.address, it.write_data, r.serial_valid, r.serial_byte);
			end
			CMD_IRQ: begin
				if (it.interrupt_index < IRQ_COUNT) iflag_copy[it.interrupt_index] = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic rsp_item_t ans(input target_t t, input logic [7:0] rd,
			input logic sv, input logic [7:0] sb);
		rsp_item_t r;
		r.target       = t;
		r.read_data    = rd;
		r.serial_valid = sv;
		r.serial_byte  = sb;
		return r;
	endfunction

	task automatic row(input cmd_t c, input logic [15:0] a, input logic [7:0] d,
			input logic [2:0] x, input bit given, input rsp_item_t want);
		req_item_t it;
		it.command         = c;
		it.address         = a;
		it.write_data      = d;
		it.interrupt_index = x;
		plan.push_back('{it, given, want});
	endtask

	// random access, mostly well-formed traffic to the internal stores
	function automatic req_item_t random_access();
		req_item_t it;
		int        pick;
		int        idx;
		it.command         = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
		it.address         = 16'($urandom);
		it.write_data      = 8'($urandom);
		it.interrupt_index = 3'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// work RAM through either window
			if (it.command == CMD_READ && wram_used.size() != 0) begin
				idx = wram_used[$urandom_range(0, wram_used.size() - 1)];
			end else begin
				it.command = CMD_WRITE;
				idx = $urandom_range(0, 8191);
			end
			if (idx < ECHO_SPAN && $urandom_range(0, 1))
				it.address = 16'(ECHO_BASE + idx);
			else
				it.address = 16'(ADDR_WRAM + idx);
		end else if (pick < 45) begin
			// high RAM
			if (it.command == CMD_READ && hram_used.size() != 0) begin
				idx = hram_used[$urandom_range(0, hram_used.size() - 1)];
			end else begin
				it.command = CMD_WRITE;
				idx = $urandom_range(0, HRAM_SPAN - 1);
			end
			it.address = 16'(ADDR_HRAM + idx);
		end else if (pick < 67) begin
			// I/O bytes, weighted towards the serial and interrupt flag registers
			case ($urandom_range(0, 5))
				0: it.address = ADDR_SB;
				1, 2: it.address = ADDR_SC;
				3: it.address = ADDR_IF;
				default: it.address = 16'(ADDR_IO + $urandom_range(0, 127));
			endcase
		end else if (pick < 77) begin
			it.command = CMD_IRQ;
		end else if (pick < 90) begin
			// forwarded regions
			if ($urandom_range(0, 4) == 0)
				it.address = 16'(ADDR_OAM + $urandom_range(0, 'h9F));
			else
				it.address = 16'($urandom_range(0, ADDR_WRAM - 1));
		end else if (pick < 97) begin
			if ($urandom_range(0, 2))
				it.address = ADDR_IE;
			else
				it.address = 16'($urandom_range(ADDR_UNUSE, ADDR_IO - 1));
		end else begin
			it.command = CMD_NONE;
		end
		return it;
	endfunction

	// offer one item, after an optional idle burst, and wait for its acceptance
	task automatic send(input req_item_t it, input bit given, input rsp_item_t want);
		int idx;
		if (!calm && tx_busy && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		if (it.command == CMD_WRITE && it.address >= ADDR_WRAM && it.address < ADDR_OAM) begin
			idx = int'(it.address[12:0]);
			if (!wram_seen[idx]) begin
				wram_seen[idx] = 1'b1;
				wram_used.push_back(idx);
			end
		end
		if (it.command == CMD_WRITE && it.address >= ADDR_HRAM && it.address < ADDR_IE) begin
			idx = int'(it.address[6:0]);
			if (!hram_seen[idx]) begin
				hram_seen[idx] = 1'b1;
				hram_used.push_back(idx);
			end
		end
		typed_rsp.push_back('{it, given, want});
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// hold the sender until every expected item has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic report_miss(input string what, input int got, input int want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch on response %0d: %s got %0h expected %0h", n_rsp, what, got, want);
	endtask

	// stimulus: reset, directed table, random traffic
	initial begin : stimulus
		int i;
		row(CMD_READ, ADDR_IF, 8'h00, 3'd0, 1'b1, ans(TGT_INTERNAL, IF_READ_SET, 1'b0, 8'h00));
		row(CMD_READ, ADDR_IE, 8'h00, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, 16'h0000, 8'h00, 3'd0, 1'b1, ans(TGT_CART_ROM, 8'h00, 1'b0, 8'h00));
		row(CMD_WRITE, 16'h9FFF, 8'hFF, 3'd7, 1'b1, ans(TGT_VIDEO, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, 16'hBFFF, 8'hFF, 3'd0, 1'b1, ans(TGT_CART_RAM, 8'h00, 1'b0, 8'h00));
		row(CMD_WRITE, ADDR_WRAM, 8'hFF, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, ADDR_WRAM, 8'h00, 3'd0, 1'b0, '0);
		row(CMD_WRITE, 16'hFDFF, 8'h00, 3'd7, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, 16'hDDFF, 8'hFF, 3'd0, 1'b0, '0);
		row(CMD_READ, ADDR_OAM, 8'h00, 3'd0, 1'b1, ans(TGT_VIDEO, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, ADDR_UNUSE, 8'h00, 3'd0, 1'b1, ans(TGT_INTERNAL, UNUSE_READ, 1'b0, 8'h00));
		row(CMD_WRITE, 16'hFEFF, 8'h55, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, ADDR_TIM_LO, 8'h00, 3'd0, 1'b1, ans(TGT_TIMER, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, ADDR_DMA, 8'h00, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_WRITE, ADDR_VBK, 8'h01, 3'd0, 1'b1, ans(TGT_VIDEO, 8'h00, 1'b0, 8'h00));
		row(CMD_WRITE, ADDR_SB, 8'hA5, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_WRITE, ADDR_SC, 8'h81, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b1, 8'hA5));
		row(CMD_READ, ADDR_SC, 8'h00, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h01, 1'b0, 8'h00));
		row(CMD_IRQ, 16'hFFFF, 8'hFF, 3'd4, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_IRQ, 16'h0000, 8'h00, 3'd7, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, ADDR_IF, 8'h00, 3'd0, 1'b0, '0);
		row(CMD_WRITE, ADDR_IF, 8'hFF, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_WRITE, 16'hFFFE, 8'h3C, 3'd0, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));
		row(CMD_READ, 16'hFFFE, 8'h00, 3'd0, 1'b0, '0);
		row(CMD_NONE, 16'hFFFF, 8'hFF, 3'd7, 1'b1, ans(TGT_INTERNAL, 8'h00, 1'b0, 8'h00));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) send(plan[k].req, plan[k].given, plan[k].rsp);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) tx_busy = $urandom_range(0, 2) != 0;
			if (i == RANDOM_ITEMS / 2) drain();
			if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
			send(random_access(), 1'b0, '0);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d accesses: %0d reads, %0d writes, %0d interrupt requests,",
			n_rsp, n_read, n_write, n_irq);
		$display("%0d unused commands and %0d serial transfer starts", n_other, n_serial);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// receiver stalls in bursts, switching between busy and quiet stretches
	initial begin : receiver
		bit rx_busy;
		rx_busy = 1'b1;
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 40) == 0) rx_busy = !rx_busy;
			if (!calm && rx_busy && $urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// predict on each accepted request, compare on each accepted response
	always @(posedge clk) begin : scoreboard
		step_t     tag;
		rsp_item_t want;
		rsp_item_t got;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				tag  = typed_rsp.pop_front();
				want = bus_access(req);
				if (tag.given) want = tag.rsp;
				case (cmd_t'(req.command))
					CMD_READ:  n_read++;
					CMD_WRITE: n_write++;
					CMD_IRQ:   n_irq++;
					default:   n_other++;
				endcase
				if (want.serial_valid) n_serial++;
				pending_rsp.push_back(want);
			end
			if (rsp_valid && !rsp_stall) begin
				got = rsp;
				if (pending_rsp.size() == 0) begin
					report_miss("unexpected item", int'(got), 0);
				end else begin
					want = pending_rsp.pop_front();
					if (got.target !== want.target)
						report_miss("target", int'(got.target), int'(want.target));
					if (got.read_data !== want.read_data)
						report_miss("read_data", int'(got.read_data), int'(want.read_data));
					if (got.serial_valid !== want.serial_valid)
						report_miss("serial_valid", int'(got.serial_valid),
							int'(want.serial_valid));
					if (got.serial_byte !== want.serial_byte)
						report_miss("serial_byte", int'(got.serial_byte),
							int'(want.serial_byte));
				end
				n_rsp++;
			end
		end
	end

	// run limit
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timed out after %0d cycles, %0d items outstanding",
				cycles, pending_rsp.size());
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
